// ===== rtl/core/acme_pkg.sv =====
// Shared types and constants of the accumulator-machine execute unit.
`default_nettype none

package acme_pkg;

    localparam int MEM_WORDS  = 4096;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_WIDTH = $clog2(MEM_WORDS);
    localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

    // Instruction codes.
    localparam logic [3:0] ACT_DEFINE = 4'd0;
    localparam logic [3:0] ACT_LDA    = 4'd1;
    localparam logic [3:0] ACT_STA    = 4'd2;
    localparam logic [3:0] ACT_ADD    = 4'd3;
    localparam logic [3:0] ACT_SUB    = 4'd4;
    localparam logic [3:0] ACT_MUL    = 4'd5;
    localparam logic [3:0] ACT_DIV    = 4'd6;
    localparam logic [3:0] ACT_XOR    = 4'd7;
    localparam logic [3:0] ACT_OR     = 4'd8;
    localparam logic [3:0] ACT_AND    = 4'd9;
    localparam logic [3:0] ACT_INC    = 4'd10;
    localparam logic [3:0] ACT_CMA    = 4'd11;
    localparam logic [3:0] ACT_CLA    = 4'd12;

    typedef struct packed {
        logic [3:0]                    action;
        logic [11:0]                   operand_address;
        logic signed [DATA_WIDTH-1:0]  write_value;
    } cmd_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  accumulator_out;
        logic                          divide_fault;
    } rsp_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_ARITH,
        ST_POST
    } exec_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIX
    } md_state_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/acme_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module acme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/acme_muldiv.sv =====
// Iterative one-bit-per-cycle multiplier and signed truncating divider.
`default_nettype none

module acme_muldiv (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire acme_pkg::md_ctl_t                ctl,
    input  wire logic [acme_pkg::DATA_WIDTH-1:0]  a,
    input  wire logic [acme_pkg::DATA_WIDTH-1:0]  b,
    output logic                                  done,
    output logic      [acme_pkg::DATA_WIDTH-1:0]  result
);

    import acme_pkg::*;

    md_state_t             state_reg, state_next;
    logic [CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic                  div_reg, div_next;
    logic                  neg_reg, neg_next;
    // x: multiplier or quotient, y: multiplicand or divisor, z: product or remainder.
    logic [DATA_WIDTH-1:0] x_reg, x_next;
    logic [DATA_WIDTH-1:0] y_reg, y_next;
    logic [DATA_WIDTH-1:0] z_reg, z_next;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] b_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    always_comb
    begin
        a_mag   = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
        b_mag   = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
        shifted = {z_reg, x_reg[DATA_WIDTH-1]};
        trial   = shifted - {1'b0, y_reg};

        state_next = state_reg;
        cnt_next   = cnt_reg;
        div_next   = div_reg;
        neg_next   = neg_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        done       = 1'b0;
        result     = z_reg;

        case (state_reg)
            MD_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = MD_RUN;
                    cnt_next   = CNT_WIDTH'(DATA_WIDTH - 1);
                    div_next   = ctl.is_div;
                    neg_next   = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
                    x_next     = ctl.is_div ? a_mag : a;
                    y_next     = ctl.is_div ? b_mag : b;
                    z_next     = '0;
                end
            end
            MD_RUN:
            begin
                if (div_reg)
                begin
                    if (!trial[DATA_WIDTH])
                    begin
                        z_next = trial[DATA_WIDTH-1:0];
                        x_next = {x_reg[DATA_WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        z_next = shifted[DATA_WIDTH-1:0];
                        x_next = {x_reg[DATA_WIDTH-2:0], 1'b0};
                    end
                end
                else
                begin
                    if (x_reg[0])
                    begin
                        z_next = z_reg + y_reg;
                    end
                    x_next = {1'b0, x_reg[DATA_WIDTH-1:1]};
                    y_next = {y_reg[DATA_WIDTH-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = MD_FIX;
                end
            end
            MD_FIX:
            begin
                done = 1'b1;
                if (div_reg)
                begin
                    result = neg_reg ? (~x_reg + 1'b1) : x_reg;
                end
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/accumulator_machine_execute_unit.sv =====
// Top level of the accumulator-machine execute unit: one instruction per item.
//
// Usage: an instruction item enters on the cmd channel (cmd_valid/cmd_ready) and
// exactly one result item leaves on the rsp channel (rsp_valid/rsp_ready): the
// accumulator after the instruction and the divide-fault bit of that instruction.
// Variables live in a 4096-word synchronous store with registered read data;
// the address is read when the item is accepted and the word is used next cycle.
// Items are processed one at a time. All instructions but MUL and DIV go from
// the execute state to the post state, which hands the result to the output
// register and returns to idle, where the next item is taken. MUL and DIV run
// on an iterative unit that retires one bit per cycle, and no new item is taken
// until its result has passed the post state. A DIV by zero skips the unit and
// takes the short path, with the fault bit set and the accumulator kept.
// After reset the accumulator is zero and the store is swept to zero, one word a
// cycle, over all 4096 words; cmd_ready stays low during that sweep.
// Results sit in an output register. If the receiver stalls, the unit can still
// accept and execute the next item; it then holds that item's result internally
// and accepts nothing further until the output register frees up.
`default_nettype none

module accumulator_machine_execute_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_ready,
    input  wire acme_pkg::cmd_item_t  cmd,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output acme_pkg::rsp_item_t       rsp
);

    import acme_pkg::*;

    exec_state_t            state_reg, state_next;
    logic [ADDR_WIDTH-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [3:0]             op_reg, op_next;
    logic [ADDR_WIDTH-1:0]  addr_reg, addr_next;
    logic [DATA_WIDTH-1:0]  wval_reg, wval_next;
    logic [DATA_WIDTH-1:0]  acc_reg, acc_next;
    logic                   fault_reg, fault_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_item_t              rsp_reg, rsp_next;

    // Store port signals.
    logic                   ram_we;
    logic [ADDR_WIDTH-1:0]  ram_waddr;
    logic [DATA_WIDTH-1:0]  ram_wdata;
    logic                   ram_re;
    logic [DATA_WIDTH-1:0]  ram_rdata;

    // Multiply/divide unit.
    md_ctl_t                md_ctl;
    logic                   md_done;
    logic [DATA_WIDTH-1:0]  md_result;

    logic                   accept;

    acme_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MEM_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cmd.operand_address[ADDR_WIDTH-1:0]),
        .rdata (ram_rdata)
    );

    acme_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (md_ctl),
        .a      (acc_reg),
        .b      (ram_rdata),
        .done   (md_done),
        .result (md_result)
    );

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            acc_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            acc_reg       <= acc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        addr_reg  <= addr_next;
        wval_reg  <= wval_next;
        fault_reg <= fault_next;
        rsp_reg   <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        wval_next      = wval_reg;
        acc_next       = acc_reg;
        fault_next     = fault_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = wval_reg;
        ram_re         = 1'b0;
        md_ctl.start   = 1'b0;
        md_ctl.is_div  = 1'b0;

        // The output register empties whenever the receiver takes the item.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero the store one word per cycle after reset.
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_WIDTH'(MEM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    ram_re     = 1'b1;
                    op_next    = cmd.action;
                    addr_next  = cmd.operand_address[ADDR_WIDTH-1:0];
                    wval_next  = cmd.write_value;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // The operand word is on the store read port this cycle.
                fault_next = 1'b0;
                state_next = ST_POST;
                case (op_reg)
                    ACT_DEFINE:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = wval_reg;
                    end
                    ACT_LDA: acc_next = ram_rdata;
                    ACT_STA:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = acc_reg;
                    end
                    ACT_ADD: acc_next = acc_reg + ram_rdata;
                    ACT_SUB: acc_next = acc_reg - ram_rdata;
                    ACT_MUL:
                    begin
                        md_ctl.start = 1'b1;
                        state_next   = ST_ARITH;
                    end
                    ACT_DIV:
                    begin
                        if (ram_rdata == '0)
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            md_ctl.start  = 1'b1;
                            md_ctl.is_div = 1'b1;
                            state_next    = ST_ARITH;
                        end
                    end
                    ACT_XOR: acc_next = acc_reg ^ ram_rdata;
                    ACT_OR:  acc_next = acc_reg | ram_rdata;
                    ACT_AND: acc_next = acc_reg & ram_rdata;
                    ACT_INC: acc_next = acc_reg + 1'b1;
                    ACT_CMA: acc_next = ~acc_reg;
                    ACT_CLA: acc_next = '0;
                    default: ;
                endcase
            end
            ST_ARITH:
            begin
                if (md_done)
                begin
                    acc_next   = md_result;
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                // Hand the result to the output register once it is free.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.accumulator_out = acc_reg;
                    rsp_next.divide_fault    = fault_reg;
                    rsp_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
